>>> design/apu_pkg.sv
package apu_pkg;

    // binary32 special patterns
    localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;
    localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;

    // configuration register indexes and reset values
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_LR  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EPS = 1'b1;
    localparam logic [31:0] LR_RESET  = 32'h3A83_126F;
    localparam logic [31:0] EPS_RESET = 32'h322B_CC77;

    // unit latencies in cycles
    localparam int unsigned SQRT_LAT = 7;
    localparam int unsigned ADD_LAT  = 5;
    localparam int unsigned DIV_LAT  = 9;
    localparam int unsigned MUL_LAT  = 3;
    localparam int unsigned TOT_LAT  = SQRT_LAT + ADD_LAT + DIV_LAT + MUL_LAT + ADD_LAT;
    localparam int unsigned TH_LAT   = SQRT_LAT + ADD_LAT + DIV_LAT + MUL_LAT;

    // unpacked operand, significand normalized to bit 23
    typedef struct packed {
        logic               sign;
        logic signed [10:0] exp;
        logic [23:0]        sig;
    } t_unpk;

    function automatic logic f_is_nan(input logic [31:0] a);
        return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    endfunction

    function automatic logic f_is_inf(input logic [31:0] a);
        return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    endfunction

    function automatic logic f_is_zero(input logic [31:0] a);
        return a[30:0] == 31'd0;
    endfunction

    function automatic logic [31:0] f_nan_pick(input logic [31:0] a, input logic [31:0] b);
        return f_is_nan(a) ? (a | QUIET_BIT) : (b | QUIET_BIT);
    endfunction

    // subnormals are normalized here, exponent may go below one
    function automatic t_unpk f_unpack(input logic [31:0] a);
        t_unpk u;
        logic [4:0] lz;
        lz = 5'd0;
        u.sign = a[31];
        if (a[30:23] != 8'd0) begin
            u.exp = {3'b000, a[30:23]};
            u.sig = {1'b1, a[22:0]};
        end else begin
            for (int k = 0; k < 23; k++) begin
                if (a[k]) begin
                    lz = 5'(23 - k);
                end
            end
            u.sig = {1'b0, a[22:0]} << lz;
            u.exp = 11'sd1 - $signed({6'd0, lz});
        end
        return u;
    endfunction

    // mant has its leading one at bit 26, bit 0 carries sticky
    function automatic logic [31:0] f_round(input logic sign, input logic signed [10:0] exp,
                                            input logic [26:0] mant);
        logic signed [10:0] d;
        logic [5:0]  sh;
        logic [53:0] w;
        logic [26:0] m2;
        logic        g;
        logic        st;
        logic        inc;
        logic [30:0] base;
        logic [30:0] res;
        d = 11'sd1 - exp;
        if (exp >= 11'sd1) begin
            sh = 6'd0;
        end else if (exp < -11'sd26) begin
            sh = 6'd28;
        end else begin
            sh = d[5:0];
        end
        w    = {mant, 27'd0} >> sh;
        m2   = w[53:27];
        g    = m2[2];
        st   = (|m2[1:0]) | (|w[26:0]);
        inc  = g & (st | m2[3]);
        base = (exp >= 11'sd1) ? {exp[7:0], m2[25:3]} : {8'd0, m2[25:3]};
        res  = base + {30'd0, inc};
        if (exp >= 11'sd255) begin
            res = {8'hFF, 23'd0};
        end
        return {sign, res};
    endfunction

endpackage

>>> design/apu_fadd.sv
module apu_fadd import apu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic        i_neg_b,
    output logic [31:0] o_res
);

    typedef struct packed {
        logic               spec;
        logic [31:0]        spec_val;
        logic               sign;
        logic               sub;
        logic signed [10:0] exp;
        logic [10:0]        diff;
        logic [23:0]        sig_big;
        logic [23:0]        sig_sml;
    } t_al;

    typedef struct packed {
        logic               spec;
        logic [31:0]        spec_val;
        logic               sign;
        logic signed [10:0] exp;
        logic [27:0]        sum;
        logic [4:0]         lz;
    } t_sm;

    typedef struct packed {
        logic               spec;
        logic [31:0]        spec_val;
        logic               sign;
        logic               zero;
        logic signed [10:0] exp;
        logic [26:0]        mant;
    } t_nm;

    t_al         r_s1, n_s1;
    t_sm         r_s2, n_s2, r_s3, n_s3;
    t_nm         r_s4, n_s4;
    logic [31:0] r_res, n_res;

    // unpack, special operands, order by magnitude
    always_comb begin
        logic [31:0] b_eff;
        t_unpk ua;
        t_unpk ub;
        logic a_big;
        b_eff = i_b ^ {i_neg_b, 31'd0};
        ua    = f_unpack(i_a);
        ub    = f_unpack(b_eff);
        a_big = (ua.exp > ub.exp) || ((ua.exp == ub.exp) && (ua.sig >= ub.sig));
        n_s1.spec     = 1'b1;
        n_s1.spec_val = 32'd0;
        if (f_is_nan(i_a) || f_is_nan(i_b)) begin
            n_s1.spec_val = f_nan_pick(i_a, i_b);
        end else if (f_is_inf(i_a) && f_is_inf(b_eff) && (i_a[31] != b_eff[31])) begin
            n_s1.spec_val = DEFAULT_NAN;
        end else if (f_is_inf(i_a)) begin
            n_s1.spec_val = i_a;
        end else if (f_is_inf(b_eff)) begin
            n_s1.spec_val = b_eff;
        end else if (f_is_zero(i_a) && f_is_zero(b_eff)) begin
            n_s1.spec_val = {i_a[31] & b_eff[31], 31'd0};
        end else if (f_is_zero(i_a)) begin
            n_s1.spec_val = b_eff;
        end else if (f_is_zero(b_eff)) begin
            n_s1.spec_val = i_a;
        end else begin
            n_s1.spec = 1'b0;
        end
        n_s1.sub     = ua.sign ^ ub.sign;
        n_s1.sign    = a_big ? ua.sign : ub.sign;
        n_s1.exp     = a_big ? ua.exp : ub.exp;
        n_s1.diff    = a_big ? 11'(ua.exp - ub.exp) : 11'(ub.exp - ua.exp);
        n_s1.sig_big = a_big ? ua.sig : ub.sig;
        n_s1.sig_sml = a_big ? ub.sig : ua.sig;
    end

    // align the smaller operand with sticky, then add or subtract
    always_comb begin
        logic [5:0]  sh;
        logic [53:0] w;
        logic [26:0] bs;
        logic [26:0] av;
        sh = (r_s1.diff > 11'd28) ? 6'd28 : r_s1.diff[5:0];
        w  = {r_s1.sig_sml, 30'd0} >> sh;
        bs = {w[53:28], w[27] | (|w[26:0])};
        av = {r_s1.sig_big, 3'b000};
        n_s2.spec     = r_s1.spec;
        n_s2.spec_val = r_s1.spec_val;
        n_s2.sign     = r_s1.sign;
        n_s2.exp      = r_s1.exp;
        n_s2.lz       = 5'd0;
        n_s2.sum      = r_s1.sub ? ({1'b0, av} - {1'b0, bs}) : ({1'b0, av} + {1'b0, bs});
    end

    // leading zero count below the carry bit
    always_comb begin
        n_s3    = r_s2;
        n_s3.lz = 5'd27;
        for (int k = 0; k < 27; k++) begin
            if (r_s2.sum[k]) begin
                n_s3.lz = 5'(26 - k);
            end
        end
    end

    // normalize
    always_comb begin
        n_s4.spec     = r_s3.spec;
        n_s4.spec_val = r_s3.spec_val;
        n_s4.sign     = r_s3.sign;
        n_s4.zero     = (r_s3.sum == 28'd0);
        if (r_s3.sum[27]) begin
            n_s4.mant = {r_s3.sum[27:2], r_s3.sum[1] | r_s3.sum[0]};
            n_s4.exp  = r_s3.exp + 11'sd1;
        end else begin
            n_s4.mant = r_s3.sum[26:0] << r_s3.lz;
            n_s4.exp  = r_s3.exp - $signed({6'd0, r_s3.lz});
        end
    end

    // round, exact cancellation gives +0
    always_comb begin
        if (r_s4.spec) begin
            n_res = r_s4.spec_val;
        end else if (r_s4.zero) begin
            n_res = 32'd0;
        end else begin
            n_res = f_round(r_s4.sign, r_s4.exp, r_s4.mant);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1  <= n_s1;
            r_s2  <= n_s2;
            r_s3  <= n_s3;
            r_s4  <= n_s4;
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

>>> design/apu_fdiv.sv
module apu_fdiv import apu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_res
);

    localparam int unsigned IT_STAGES = 7;
    localparam int unsigned IT_STEPS  = 4;

    typedef struct packed {
        logic               spec;
        logic [31:0]        spec_val;
        logic               sign;
        logic signed [10:0] exp;
        logic [23:0]        den;
        logic [24:0]        rem;
        logic [27:0]        quo;
    } t_dit;

    t_dit        r_it [IT_STAGES+1];
    t_dit        n_it0;
    logic [31:0] r_res, n_res;

    // restoring division, one quotient bit per step
    function automatic t_dit f_step(input t_dit x);
        t_dit y;
        logic ge;
        y = x;
        for (int k = 0; k < IT_STEPS; k++) begin
            ge = (y.rem >= {1'b0, y.den});
            if (ge) begin
                y.rem = y.rem - {1'b0, y.den};
            end
            y.quo = {y.quo[26:0], ge};
            y.rem = {y.rem[23:0], 1'b0};
        end
        return y;
    endfunction

    always_comb begin
        t_unpk ua;
        t_unpk ub;
        ua = f_unpack(i_a);
        ub = f_unpack(i_b);
        n_it0.spec     = 1'b1;
        n_it0.spec_val = 32'd0;
        if (f_is_nan(i_a) || f_is_nan(i_b)) begin
            n_it0.spec_val = f_nan_pick(i_a, i_b);
        end else if ((f_is_zero(i_a) && f_is_zero(i_b)) || (f_is_inf(i_a) && f_is_inf(i_b)))
        begin
            n_it0.spec_val = DEFAULT_NAN;
        end else if (f_is_zero(i_b) || f_is_inf(i_a)) begin
            n_it0.spec_val = {i_a[31] ^ i_b[31], 8'hFF, 23'd0};
        end else if (f_is_zero(i_a) || f_is_inf(i_b)) begin
            n_it0.spec_val = {i_a[31] ^ i_b[31], 31'd0};
        end else begin
            n_it0.spec = 1'b0;
        end
        n_it0.sign = ua.sign ^ ub.sign;
        n_it0.exp  = ua.exp - ub.exp + 11'sd127;
        n_it0.den  = ub.sig;
        n_it0.rem  = {1'b0, ua.sig};
        n_it0.quo  = 28'd0;
    end

    // quotient below one needs the extra bit
    always_comb begin
        t_dit        f;
        logic        rnz;
        logic [26:0] mant;
        logic signed [10:0] e;
        f   = r_it[IT_STAGES];
        rnz = (f.rem != 25'd0);
        if (f.quo[27]) begin
            mant = {f.quo[27:2], f.quo[1] | f.quo[0] | rnz};
            e    = f.exp;
        end else begin
            mant = {f.quo[26:1], f.quo[0] | rnz};
            e    = f.exp - 11'sd1;
        end
        n_res = f.spec ? f.spec_val : f_round(f.sign, e, mant);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_it[0] <= n_it0;
            for (int s = 0; s < IT_STAGES; s++) begin
                r_it[s+1] <= f_step(r_it[s]);
            end
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

>>> design/adam_parameter_update.sv
// channel   direction  handshake            payload
// -------   ---------  -------------------  -----------------------------------------------
// in        input      i_valid / o_stall    i_param_value, i_first_moment, i_second_moment,
//                                           i_last_element
// out       output     o_valid / i_stall    o_updated_value, o_last_out
// config    input      i_cfg_we             i_cfg_index, i_cfg_data (learning rate, epsilon)
//
// one item enters per cycle while o_stall is low; each item taken passes in turn through
//   the unit pipelines: sqrt, add, divide, multiply, subtract
// the divider's 28 quotient steps (four per stage) set the divider's depth
// synchronous active-low reset clears the valid line and loads the register defaults
// one stall freezes every stage at once, so bubbles are kept and nothing is lost
// o_stall is high only while a finished item waits at the output and i_stall is high
module adam_parameter_update import apu_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input channel
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [31:0]          i_param_value,
    input  logic [31:0]          i_first_moment,
    input  logic [31:0]          i_second_moment,
    input  logic                 i_last_element,
    // output channel
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [31:0]          o_updated_value,
    output logic                 o_last_out,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    localparam int unsigned SQ_STAGES = 5;
    localparam int unsigned SQ_STEPS  = 5;

    // sqrt iteration state: radicand bits still to bring down, partial root
    typedef struct packed {
        logic               spec;
        logic [31:0]        spec_val;
        logic signed [10:0] exp;
        logic [49:0]        x;
        logic [26:0]        rem;
        logic [24:0]        root;
    } t_sit;

    typedef struct packed {
        logic               spec;
        logic [31:0]        spec_val;
        logic               sign;
        logic signed [10:0] exp;
        logic [23:0]        sig_a;
        logic [23:0]        sig_b;
    } t_mop;

    typedef struct packed {
        logic               spec;
        logic [31:0]        spec_val;
        logic               sign;
        logic signed [10:0] exp;
        logic [47:0]        prod;
    } t_mpr;

    logic        en;

    // configuration registers
    logic [31:0] r_lr;
    logic [31:0] r_eps;

    // valid, frame flag and theta travel beside the units
    logic        r_vld   [TOT_LAT];
    logic        r_last  [TOT_LAT];
    logic [31:0] r_theta [TH_LAT];

    // sqrt stages
    t_sit        r_sq [SQ_STAGES+1];
    t_sit        n_sq0;
    logic [31:0] r_sq_res, n_sq_res;

    // multiplier stages
    t_mop        r_m1, n_m1;
    t_mpr        r_m2, n_m2;
    logic [31:0] r_m3, n_m3;

    logic [31:0] w_den;
    logic [31:0] w_quo;

    // first moment delayed to meet the denominator
    logic [31:0] r_mom [SQRT_LAT+ADD_LAT];
    logic [31:0] w_div_num;

    // whole pipeline moves unless the output item is held
    assign o_stall = r_vld[TOT_LAT-1] & i_stall;
    assign en      = ~o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr  <= LR_RESET;
            r_eps <= EPS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LR:  r_lr  <= i_cfg_data;
                CFG_EPS: r_eps <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TOT_LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < TOT_LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_last[0]  <= i_last_element;
            r_theta[0] <= i_param_value;
            for (int k = 1; k < TOT_LAT; k++) begin
                r_last[k] <= r_last[k-1];
            end
            for (int k = 1; k < TH_LAT; k++) begin
                r_theta[k] <= r_theta[k-1];
            end
        end
    end

    // ---------------- square root ----------------

    // digit by digit integer root, one root bit per step
    function automatic t_sit f_sq_step(input t_sit x);
        t_sit        y;
        logic [28:0] r2;
        logic [28:0] trial;
        logic        ge;
        y = x;
        for (int k = 0; k < SQ_STEPS; k++) begin
            r2    = {y.rem, y.x[49:48]};
            trial = {2'b00, y.root, 2'b01};
            ge    = (r2 >= trial);
            if (ge) begin
                r2 = r2 - trial;
            end
            y.rem  = r2[26:0];
            y.root = {y.root[23:0], ge};
            y.x    = {y.x[47:0], 2'b00};
        end
        return y;
    endfunction

    // radicand scaled to 49 or 50 bits so the exponent halves exactly
    always_comb begin
        t_unpk u;
        logic signed [10:0] t;
        logic signed [10:0] ts;
        logic odd;
        u   = f_unpack(i_second_moment);
        odd = u.exp[0];
        t   = u.exp - 11'sd150;
        ts  = t - (odd ? 11'sd25 : 11'sd26);
        n_sq0.spec     = 1'b1;
        n_sq0.spec_val = 32'd0;
        if (f_is_nan(i_second_moment)) begin
            n_sq0.spec_val = i_second_moment | QUIET_BIT;
        end else if (f_is_zero(i_second_moment)) begin
            n_sq0.spec_val = i_second_moment;
        end else if (i_second_moment[31]) begin
            n_sq0.spec_val = DEFAULT_NAN;
        end else if (f_is_inf(i_second_moment)) begin
            n_sq0.spec_val = i_second_moment;
        end else begin
            n_sq0.spec = 1'b0;
        end
        n_sq0.exp  = 11'sd151 + (ts >>> 1);
        n_sq0.x    = odd ? {1'b0, u.sig, 25'd0} : {u.sig, 26'd0};
        n_sq0.rem  = 27'd0;
        n_sq0.root = 25'd0;
    end

    // the root's lowest bit is the round bit, the remainder the sticky
    always_comb begin
        t_sit f;
        f = r_sq[SQ_STAGES];
        if (f.spec) begin
            n_sq_res = f.spec_val;
        end else begin
            n_sq_res = f_round(1'b0, f.exp, {f.root, 1'b0, f.rem != 27'd0});
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq[0] <= n_sq0;
            for (int s = 0; s < SQ_STAGES; s++) begin
                r_sq[s+1] <= f_sq_step(r_sq[s]);
            end
            r_sq_res <= n_sq_res;
        end
    end

    // ---------------- sqrt(v) + eps ----------------

    apu_fadd u_add (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_a     (r_sq_res),
        .i_b     (r_eps),
        .i_neg_b (1'b0),
        .o_res   (w_den)
    );

    // ---------------- m / s ----------------

    apu_fdiv u_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (w_div_num),
        .i_b   (w_den),
        .o_res (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mom[0] <= i_first_moment;
            for (int k = 1; k < SQRT_LAT + ADD_LAT; k++) begin
                r_mom[k] <= r_mom[k-1];
            end
        end
    end

    assign w_div_num = r_mom[SQRT_LAT+ADD_LAT-1];

    // ---------------- lr * q ----------------

    always_comb begin
        t_unpk ua;
        t_unpk ub;
        ua = f_unpack(r_lr);
        ub = f_unpack(w_quo);
        n_m1.spec     = 1'b1;
        n_m1.spec_val = 32'd0;
        if (f_is_nan(r_lr) || f_is_nan(w_quo)) begin
            n_m1.spec_val = f_nan_pick(r_lr, w_quo);
        end else if ((f_is_inf(r_lr) && f_is_zero(w_quo)) ||
                     (f_is_zero(r_lr) && f_is_inf(w_quo))) begin
            n_m1.spec_val = DEFAULT_NAN;
        end else if (f_is_inf(r_lr) || f_is_inf(w_quo)) begin
            n_m1.spec_val = {r_lr[31] ^ w_quo[31], 8'hFF, 23'd0};
        end else if (f_is_zero(r_lr) || f_is_zero(w_quo)) begin
            n_m1.spec_val = {r_lr[31] ^ w_quo[31], 31'd0};
        end else begin
            n_m1.spec = 1'b0;
        end
        n_m1.sign  = ua.sign ^ ub.sign;
        n_m1.exp   = ua.exp + ub.exp - 11'sd127;
        n_m1.sig_a = ua.sig;
        n_m1.sig_b = ub.sig;
    end

    always_comb begin
        n_m2.spec     = r_m1.spec;
        n_m2.spec_val = r_m1.spec_val;
        n_m2.sign     = r_m1.sign;
        n_m2.exp      = r_m1.exp;
        n_m2.prod     = r_m1.sig_a * r_m1.sig_b;
    end

    // product of normalized significands needs at most one bit of shift
    always_comb begin
        logic [26:0] mant;
        logic signed [10:0] e;
        if (r_m2.prod[47]) begin
            mant = {r_m2.prod[47:22], |r_m2.prod[21:0]};
            e    = r_m2.exp + 11'sd1;
        end else begin
            mant = {r_m2.prod[46:21], |r_m2.prod[20:0]};
            e    = r_m2.exp;
        end
        n_m3 = r_m2.spec ? r_m2.spec_val : f_round(r_m2.sign, e, mant);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m1 <= n_m1;
            r_m2 <= n_m2;
            r_m3 <= n_m3;
        end
    end

    // ---------------- theta - p ----------------

    apu_fadd u_sub (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_a     (r_theta[TH_LAT-1]),
        .i_b     (r_m3),
        .i_neg_b (1'b1),
        .o_res   (o_updated_value)
    );

    assign o_valid    = r_vld[TOT_LAT-1];
    assign o_last_out = r_last[TOT_LAT-1];

    // ---------------- checks ----------------

    // any NaN leaving the block is quiet
    a_quiet_nan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !((o_updated_value[30:23] == 8'hFF) && (o_updated_value[22:0] != 23'd0)
                      && !o_updated_value[22]))
        else $error("signaling nan at output");

    // a square root is never negative apart from -0 and NaN
    a_sqrt_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[SQRT_LAT-1] && r_sq_res[31]) |->
            ((r_sq_res[30:0] == 31'd0) || (r_sq_res[30:23] == 8'hFF)))
        else $error("negative square root");

    // a stall holds the valid line; its first entry and the entry at TH_LAT-1 are checked
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> ($stable(r_vld[0]) && $stable(r_vld[TH_LAT-1])))
        else $error("pipeline moved under stall");

endmodule

>>> dv/adam_update_checker.sv
`timescale 1ns / 1ps

// watches both channels of the adam update block, predicts each updated value
// bit for bit and compares it with what comes out
module adam_update_checker import apu_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [31:0]          i_theta,
    input  logic [31:0]          i_moment1,
    input  logic [31:0]          i_moment2,
    input  logic                 i_last,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [31:0]          i_updated,
    input  logic                 i_last_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        logic [31:0] value;
        logic        last;
    } t_update;

    t_update     update_q[$];
    logic [31:0] lr_reg;
    logic [31:0] eps_reg;

    function automatic logic is_nan(input logic [31:0] a);
        return a[30:0] > 31'h7F80_0000;
    endfunction

    function automatic logic is_inf(input logic [31:0] a);
        return a[30:0] == 31'h7F80_0000;
    endfunction

    function automatic logic is_zero(input logic [31:0] a);
        return a[30:0] == 31'd0;
    endfunction

    function automatic logic [31:0] quiet_of(input logic [31:0] a, input logic [31:0] b);
        return is_nan(a) ? (a | QUIET_BIT) : (b | QUIET_BIT);
    endfunction

    // value = sig * 2^e
    function automatic void split(input logic [31:0] a, output int e, output logic [63:0] s);
        if (a[30:23] == 8'd0) begin
            s = {41'd0, a[22:0]};
            e = -149;
        end else begin
            s = {40'd0, 1'b1, a[22:0]};
            e = int'(a[30:23]) - 150;
        end
    endfunction

    function automatic void normalize(inout int e, inout logic [63:0] s);
        while (s[23] == 1'b0) begin
            s = s << 1;
            e = e - 1;
        end
    endfunction

    // exact value sig * 2^e, sticky folded into the low bit, rounded to nearest even
    function automatic logic [31:0] pack_rne(input logic sgn, input int e, input logic [63:0] sig);
        int          p;
        int          x;
        int          be;
        int          sh;
        logic [63:0] m;
        logic        g;
        logic        st;
        longint      res;
        if (sig == 64'd0) return {sgn, 31'd0};
        p = 0;
        for (int k = 0; k < 64; k++) begin
            if (sig[k]) p = k;
        end
        x  = e + p;
        be = (x + 127 >= 1) ? x + 127 : 1;
        sh = (be - 150) - e;
        g  = 1'b0;
        st = 1'b0;
        if (sh <= 0) begin
            m = sig << (-sh);
        end else if (sh >= 64) begin
            m  = 64'd0;
            st = 1'b1;
        end else begin
            m  = sig >> sh;
            g  = sig[sh-1];
            st = (sig & ((64'd1 << (sh - 1)) - 64'd1)) != 64'd0;
        end
        if (g && (st || m[0])) m = m + 64'd1;
        res = (longint'(be) << 23) + longint'(m) - 64'sd8388608;
        if (res >= 64'sh7F80_0000) res = 64'sh7F80_0000;
        return {sgn, res[30:0]};
    endfunction

    // both operands known not to be NaN
    function automatic logic [31:0] add_core(input logic [31:0] a, input logic [31:0] b);
        int          ea;
        int          eb;
        int          d;
        logic [63:0] sa;
        logic [63:0] sb;
        logic [63:0] big;
        logic [63:0] tiny;
        logic [31:0] t;
        if (is_inf(a) && is_inf(b) && (a[31] != b[31])) return DEFAULT_NAN;
        if (is_inf(a)) return a;
        if (is_inf(b)) return b;
        split(a, ea, sa);
        split(b, eb, sb);
        if (ea < eb) begin
            t = a; a = b; b = t;
            d = ea; ea = eb; eb = d;
            big = sa; sa = sb; sb = big;
        end
        d = ea - eb;
        if (d <= 38) begin
            big  = sa << d;
            tiny = sb;
        end else begin
            // far smaller operand only matters as sticky
            big  = sa << 5;
            tiny = (sb != 64'd0) ? 64'd1 : 64'd0;
            eb   = ea - 5;
        end
        if (a[31] == b[31]) return pack_rne(a[31], eb, big + tiny);
        if (big == tiny) return 32'd0;
        if (big > tiny) return pack_rne(a[31], eb, big - tiny);
        return pack_rne(b[31], eb, tiny - big);
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        if (is_nan(a) || is_nan(b)) return quiet_of(a, b);
        return add_core(a, b);
    endfunction

    function automatic logic [31:0] fp_sub(input logic [31:0] a, input logic [31:0] b);
        if (is_nan(a) || is_nan(b)) return quiet_of(a, b);
        return add_core(a, {~b[31], b[30:0]});
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        int          ea;
        int          eb;
        logic [63:0] sa;
        logic [63:0] sb;
        logic        sg;
        if (is_nan(a) || is_nan(b)) return quiet_of(a, b);
        if ((is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b))) return DEFAULT_NAN;
        sg = a[31] ^ b[31];
        if (is_inf(a) || is_inf(b)) return {sg, 31'h7F80_0000};
        split(a, ea, sa);
        split(b, eb, sb);
        return pack_rne(sg, ea + eb, sa * sb);
    endfunction

    function automatic logic [31:0] fp_div(input logic [31:0] a, input logic [31:0] b);
        int          ea;
        int          eb;
        logic [63:0] sa;
        logic [63:0] sb;
        logic [63:0] num;
        logic [63:0] quo;
        logic        sg;
        if (is_nan(a) || is_nan(b)) return quiet_of(a, b);
        if ((is_zero(a) && is_zero(b)) || (is_inf(a) && is_inf(b))) return DEFAULT_NAN;
        sg = a[31] ^ b[31];
        if (is_zero(b) || is_inf(a)) return {sg, 31'h7F80_0000};
        if (is_inf(b) || is_zero(a)) return {sg, 31'd0};
        split(a, ea, sa);
        split(b, eb, sb);
        normalize(ea, sa);
        normalize(eb, sb);
        num = sa << 39;
        quo = num / sb;
        if (num % sb != 64'd0) quo[0] = 1'b1;
        return pack_rne(sg, ea - 39 - eb, quo);
    endfunction

    function automatic logic [31:0] fp_sqrt(input logic [31:0] a);
        int          e;
        logic [63:0] s;
        logic [63:0] n;
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] bitv;
        if (is_nan(a)) return a | QUIET_BIT;
        if (is_zero(a)) return a;
        if (a[31]) return DEFAULT_NAN;
        if (is_inf(a)) return a;
        split(a, e, s);
        normalize(e, s);
        if (e[0]) begin
            s = s << 1;
            e = e - 1;
        end
        n    = s << 38;
        rem  = n;
        root = 64'd0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 64'd0) begin
            if (rem >= root + bitv) begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        if (rem != 64'd0) root[0] = 1'b1;
        return pack_rne(1'b0, (e - 38) / 2, root);
    endfunction

    function automatic logic [31:0] adam_step(input logic [31:0] theta, input logic [31:0] m1,
                                              input logic [31:0] m2);
        logic [31:0] den;
        den = fp_add(fp_sqrt(m2), eps_reg);
        return fp_sub(theta, fp_mul(lr_reg, fp_div(m1, den)));
    endfunction

    assign o_pending = update_q.size();

    always @(posedge i_clk) begin
        t_update got;
        t_update want;
        if (!i_rst_n) begin
            lr_reg  <= LR_RESET;
            eps_reg <= EPS_RESET;
            update_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_LR) lr_reg <= i_cfg_data;
                else if (i_cfg_index == CFG_EPS) eps_reg <= i_cfg_data;
            end
            if (i_out_valid && !i_out_stall) begin
                got.value = i_updated;
                got.last  = i_last_out;
                if (update_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result %h last %b", got.value, got.last);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = update_q.pop_front();
                    if (got !== want) begin
                        if (o_fail_count < 10)
                            $display("mismatch: expected %h last %b, got %h last %b",
                                     want.value, want.last, got.value, got.last);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                want.value = adam_step(i_theta, i_moment1, i_moment2);
                want.last  = i_last;
                update_q = {update_q, want};
            end
        end
    end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

// adam update testbench: directed corner items, then random phases under
// several learning rate / epsilon settings, with random idling on both sides
module tb_top;
    import apu_pkg::*;

    localparam int IDLE_LIMIT = 4000;   // cycles with no item moving on either channel
    localparam int SETTLE     = 40;     // more than the pipeline depth

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [31:0]          i_param_value = '0;
    logic [31:0]          i_first_moment = '0;
    logic [31:0]          i_second_moment = '0;
    logic                 i_last_element = 1'b0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [31:0]          o_updated_value;
    logic                 o_last_out;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_LR;
    logic [31:0]          i_cfg_data = '0;

    int   fail_count;
    int   pending;
    logic quiet = 1'b0;        // no idling in the last part of the run
    int   stall_left = 0;
    int   idle_cycles = 0;

    always #2 i_clk = ~i_clk;

    adam_parameter_update u_top (.*);

    adam_update_checker u_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_stall  (o_stall),
        .i_theta     (i_param_value),
        .i_moment1   (i_first_moment),
        .i_moment2   (i_second_moment),
        .i_last      (i_last_element),
        .i_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_updated   (o_updated_value),
        .i_last_out  (o_last_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // receiver back-pressure: alternating stall / free bursts
    always @(negedge i_clk) begin
        if (quiet) begin
            i_stall <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            i_stall    <= ~i_stall;
            stall_left <= $urandom_range(1, 19);
        end
    end

    // watchdog on traffic, not on total run time
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // random binary32 pattern, biased toward the interesting classes
    function automatic logic [31:0] rand_float(input logic positive);
        logic [31:0] f;
        case ($urandom_range(0, 9))
            0, 1: f = $urandom;
            2: f = {1'b0, 8'h00, 23'($urandom)};                       // subnormal
            3: begin
                case ($urandom_range(0, 5))
                    0: f = 32'h0000_0000;
                    1: f = 32'h7F80_0000;                              // infinity
                    2: f = {1'b0, 8'hFF, 1'b0, 22'($urandom) | 22'd1}; // signaling nan
                    3: f = {1'b0, 8'hFF, 1'b1, 22'($urandom)};         // quiet nan
                    4: f = 32'h7F7F_FFFF;
                    default: f = 32'h0000_0001;
                endcase
                f[31] = 1'($urandom_range(0, 1));
            end
            default: f = {1'($urandom), 8'($urandom_range(96, 140)), 23'($urandom)};
        endcase
        if (positive && $urandom_range(0, 7) != 0) f[31] = 1'b0;
        return f;
    endfunction

    // one item; returns at the falling edge after it was taken
    task automatic push_item(input logic [31:0] theta, input logic [31:0] m1,
                             input logic [31:0] m2, input logic last);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_param_value   <= theta;
        i_first_moment  <= m1;
        i_second_moment <= m2;
        i_last_element  <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // drain the pipeline so the registers can change safely
    task automatic drain();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic random_items(input int count);
        for (int n = 0; n < count; n++) begin
            push_item(rand_float(1'b0), rand_float(1'b0), rand_float(1'b1),
                      $urandom_range(0, 15) == 0);
        end
    endtask

    logic [31:0] lr_set[6]  = '{32'h3F80_0000, 32'h7F7F_FFFF, 32'h0000_0000,
                                32'h0000_0000, 32'hFFFF_FFFF, LR_RESET};
    logic [31:0] eps_set[6] = '{32'h0000_0000, 32'h0000_0001, 32'h7F80_0000,
                                32'h0000_0000, 32'hFFFF_FFFF, EPS_RESET};

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed corners under the reset learning rate and epsilon
        push_item(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
        push_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        push_item(32'h3F80_0000, 32'h3DCC_CCCD, 32'h3C23_D70A, 1'b0);
        push_item(32'h7F80_0000, 32'h3F80_0000, 32'h3F80_0000, 1'b0);  // theta infinite
        push_item(32'h7F80_0000, 32'h7F80_0000, 32'h0000_0000, 1'b0);  // inf - inf
        push_item(32'hFF80_0000, 32'hFF80_0000, 32'h0000_0000, 1'b1);
        push_item(32'h3F80_0000, 32'h7F80_0000, 32'h7F80_0000, 1'b0);  // inf / inf
        push_item(32'h7F80_0001, 32'h7FA0_0000, 32'h7FB0_0000, 1'b0);  // nans, theta first
        push_item(32'h3F80_0000, 32'hFFA0_0001, 32'h7F90_0000, 1'b0);  // nans in m and v
        push_item(32'h3F80_0000, 32'h3F80_0000, 32'h7F90_0000, 1'b0);  // nan in v
        push_item(32'h3F80_0000, 32'h3F80_0000, 32'hBF80_0000, 1'b0);  // sqrt of negative
        push_item(32'h3F80_0000, 32'h3F80_0000, 32'hFF80_0000, 1'b0);  // sqrt of -inf
        push_item(32'h3F80_0000, 32'h3F80_0000, 32'h8000_0000, 1'b0);  // sqrt of -0
        push_item(32'h3F80_0000, 32'h3F80_0000, 32'h7F80_0000, 1'b0);  // sqrt of +inf
        push_item(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 1'b0);  // subnormals
        push_item(32'h807F_FFFF, 32'h007F_FFFF, 32'h0000_0003, 1'b0);
        push_item(32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h0000_0000, 1'b0);  // overflow
        push_item(32'h8000_0000, 32'h8000_0000, 32'h3F80_0000, 1'b1);
        push_item(32'h3A83_126F, 32'h3A83_126F, 32'h3A83_126F, 1'b0);
        random_items(220);

        // every phase starts from a drained pipeline
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            write_reg(CFG_LR, lr_set[ph]);
            write_reg(CFG_EPS, eps_set[ph]);
            if (ph == 3) begin
                write_reg(CFG_LR, $urandom);
                write_reg(CFG_EPS, $urandom);
            end
            if (ph == 0) begin
                // zero epsilon opens 0/0 and x/0 in the divider
                push_item(32'h3F80_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
                push_item(32'h3F80_0000, 32'h3F80_0000, 32'h0000_0000, 1'b0);
                push_item(32'h3F80_0000, 32'hBF80_0000, 32'h8000_0000, 1'b1);
            end
            if (ph == 5) quiet = 1'b1;
            random_items((ph == 4) ? 120 : 250);
        end

        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> adam_parameter_update.f
design/apu_pkg.sv
design/apu_fadd.sv
design/apu_fdiv.sv
design/adam_parameter_update.sv
dv/adam_update_checker.sv
dv/tb_top.sv
